@@ src/itst_pkg.sv @@
// Package for the interpolating time-series table.
// Holds sizes, command and status codes, the state enum and the lane control struct.
package itst_pkg;

    localparam int Depth = 64;
    localparam int AddrW = $clog2(Depth);
    localparam int CountW = $clog2(Depth + 1);
    localparam int NumCols = 4;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BAD_IDX  = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOT_INCR = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_WAIT,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SEARCH,
        S_SEARCH_WAIT,
        S_PREV_RD,
        S_PREV_WAIT,
        S_DIV,
        S_OUT
    } state_t;

    // Operands handed to every interpolation lane.
    typedef struct packed {
        logic        start;
        logic [31:0] dt;
        logic [31:0] span;
    } lane_ctl_t;

endpackage

@@ src/interpolating_time_series_table.sv @@
// Interpolating time-series table, top level.
// Depends on itst_pkg and itst_ctrl (which holds the lanes).
//
// Usage: input transactions carry cmd, time_in, row_index and four values;
// one is accepted when in_valid is high and in_stall low. Each command gives
// exactly one result transaction (status, time_out, value_out0..3,
// row_count), taken when out_valid is high and out_stall low.
// The user writes the column count on cfg_valid/cfg_ready only while idle;
// the block does not enforce this. Steps per command: append, bad index and
// empty table go straight to the result; a query outside the range checks
// the cached bounds; a read, and a query on the first time, fetch one row;
// remove fetches the row below, then shifts each later row down by one; an
// interpolating query does at most 6 binary search steps, then one multiply
// and a 65-step divide in each lane.
// One command is in flight at a time; in_stall is high while working and
// while a result waits, so the next command is taken the cycle after the
// result is accepted.
// Reset empties the table and sets the column count to one; row storage
// is not cleared. While out_stall is high the result holds and no new
// command is taken.
module interpolating_time_series_table (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic [31:0]         time_in,
    input  logic [5:0]          row_index,
    input  logic signed [31:0]  value_in0,
    input  logic signed [31:0]  value_in1,
    input  logic signed [31:0]  value_in2,
    input  logic signed [31:0]  value_in3,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          status,
    output logic [31:0]         time_out,
    output logic signed [31:0]  value_out0,
    output logic signed [31:0]  value_out1,
    output logic signed [31:0]  value_out2,
    output logic signed [31:0]  value_out3,
    output logic [6:0]          row_count,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_data
);
    import itst_pkg::*;

    logic       busy;
    logic       in_fire;
    logic [2:0] cols_reg;
    logic [127:0] vals;
    status_t    st;

    assign in_stall  = busy || out_valid;
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Hold the column count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cols_reg <= 3'd1;
        else if (cfg_valid && cfg_ready)
            cols_reg <= cfg_data;
    end

    itst_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cols_cfg   (cols_reg),
        .in_fire    (in_fire),
        .in_cmd     (cmd_t'(cmd)),
        .in_time    (time_in),
        .in_idx     (row_index),
        .in_vals    ({value_in3, value_in2, value_in1, value_in0}),
        .busy       (busy),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_status (st),
        .out_time   (time_out),
        .out_vals   (vals),
        .out_count  (row_count)
    );

    assign status     = 3'(st);
    assign value_out0 = vals[31:0];
    assign value_out1 = vals[63:32];
    assign value_out2 = vals[95:64];
    assign value_out3 = vals[127:96];

endmodule

@@ src/itst_lane.sv @@
// One interpolation lane: offset = trunc((t - t1) * (y2 - y1) / span) + y1.
// Depends on itst_pkg; multiplies once, then divides one bit per cycle.
module itst_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  itst_pkg::lane_ctl_t ctl,
    input  logic signed [31:0]  y1,
    input  logic signed [31:0]  y2,
    output logic                done,
    output logic signed [31:0]  result
);
    import itst_pkg::*;

    logic [6:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               mul_reg, mul_next;
    logic               neg_reg, neg_next;
    logic [32:0]        mag_reg, mag_next;
    logic [64:0]        num_reg, num_next;
    logic [32:0]        rem_reg, rem_next;
    logic [31:0]        span_reg, span_next;
    logic signed [31:0] y1_reg, y1_next;
    logic [31:0]        dt_reg, dt_next;

    logic signed [32:0] dy;
    logic [33:0]        trial;
    logic [64:0]        qmag;
    logic signed [34:0] sum;

    assign dy = 33'(y2) - 33'(y1);

    // Sequence multiply then restoring division of a 65-bit numerator
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        mul_next  = 1'b0;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        span_next = span_reg;
        y1_next   = y1_reg;
        dt_next   = dt_reg;
        trial     = {rem_reg, num_reg[64]};
        if (ctl.start)
        begin
            neg_next  = dy[32];
            mag_next  = dy[32] ? 33'(-dy) : 33'(dy);
            span_next = ctl.span;
            dt_next   = ctl.dt;
            y1_next   = y1;
            mul_next  = 1'b1;
            busy_next = 1'b0;
        end
        else if (mul_reg)
        begin
            num_next  = 65'(mag_reg) * 65'(dt_reg);
            rem_next  = '0;
            cnt_next  = 7'd65;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one numerator bit, subtract when it fits
            if (trial >= {2'b00, span_reg})
            begin
                rem_next = 33'(trial - {2'b00, span_reg});
                num_next = {num_reg[63:0], 1'b1};
            end
            else
            begin
                rem_next = trial[32:0];
                num_next = {num_reg[63:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            mul_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            mul_reg  <= mul_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        span_reg <= span_next;
        y1_reg   <= y1_next;
        dt_reg   <= dt_next;
    end

    // Apply the sign to the truncated quotient and add the base value
    assign qmag   = num_reg;
    assign sum    = neg_reg ? 35'(y1_reg) - 35'(qmag[33:0])
                            : 35'(y1_reg) + 35'(qmag[33:0]);
    assign result = sum[31:0];
    assign done   = !busy_reg && !mul_reg && !ctl.start;

endmodule

@@ src/itst_ctrl.sv @@
// Sequencer and row storage for the time-series table.
// Depends on itst_pkg; drives the lanes and merges their results.
module itst_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [2:0]                cols_cfg,
    input  logic                      in_fire,
    input  itst_pkg::cmd_t            in_cmd,
    input  logic [31:0]               in_time,
    input  logic [5:0]                in_idx,
    input  logic [4*32-1:0]           in_vals,
    output logic                      busy,
    input  logic                      out_stall,
    output logic                      out_valid,
    output itst_pkg::status_t         out_status,
    output logic [31:0]               out_time,
    output logic [4*32-1:0]           out_vals,
    output logic [6:0]                out_count
);
    import itst_pkg::*;

    logic [31:0]  times_mem [Depth];
    logic [127:0] vals_mem  [Depth];
    logic [31:0]  rd_time_reg;
    logic [127:0] rd_vals_reg;

    state_t       state_reg, state_next;
    cmd_t         cmd_reg;
    logic [31:0]  t_reg;
    logic [AddrW-1:0] idx_reg, idx_next;
    logic [CountW-1:0] count_reg, count_next;
    logic [31:0]  last_time_reg, last_time_next;
    logic [31:0]  first_time_reg, first_time_next;
    logic [31:0]  t1_reg, t1_next;
    logic [31:0]  t2_reg, t2_next;
    logic [127:0] y2_reg, y2_next;
    logic [AddrW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid;
    logic [6:0]   steps_reg, steps_next;
    logic [2:0]   ncols;
    status_t      st_reg, st_next;
    logic [31:0]  tout_reg, tout_next;
    logic [127:0] vout_reg, vout_next;
    logic         ovalid_reg, ovalid_next;

    logic            rd_en, wr_en;
    logic [AddrW-1:0] rd_addr, wr_addr;
    logic [31:0]     wr_time;
    logic [127:0]    wr_vals;

    lane_ctl_t   lctl;
    logic [3:0]  ldone;
    logic [127:0] lres;

    // Clamp the column count to the supported range
    always_comb
    begin
        if (cols_cfg == 3'd0)
            ncols = 3'd1;
        else if (cols_cfg > 3'(NumCols))
            ncols = 3'(NumCols);
        else
            ncols = cols_cfg;
    end

    assign mid = AddrW'((({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1));

    // Storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            times_mem[wr_addr] <= wr_time;
            vals_mem[wr_addr]  <= wr_vals;
        end
        if (rd_en)
        begin
            rd_time_reg <= times_mem[rd_addr];
            rd_vals_reg <= vals_mem[rd_addr];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    if (in_cmd == CMD_APPEND)
                        state_next = S_OUT;
                    else if (in_cmd == CMD_QUERY)
                        state_next = (count_reg == '0) ? S_OUT : S_DECIDE;
                    else
                        state_next = (CountW'(in_idx) >= count_reg) ? S_OUT : S_RD;
                end
            S_RD:          state_next = S_WAIT;
            S_WAIT:        state_next = (cmd_reg == CMD_REMOVE) ? S_SHIFT_RD : S_OUT;
            S_DECIDE:
                if (t_reg == first_time_reg || t_reg < first_time_reg
                    || t_reg > last_time_reg)
                    state_next = (t_reg == first_time_reg) ? S_RD : S_OUT;
                else
                    state_next = S_SEARCH;
            S_SHIFT_RD:
                state_next = (CountW'(idx_reg) + 1'b1 >= count_reg) ? S_OUT : S_SHIFT_WR;
            S_SHIFT_WR:    state_next = S_SHIFT_RD;
            S_SEARCH:      state_next = (lo_reg == hi_reg) ? S_PREV_RD : S_SEARCH_WAIT;
            S_SEARCH_WAIT: state_next = S_SEARCH;
            S_PREV_RD:     state_next = S_PREV_WAIT;
            S_PREV_WAIT:   state_next = S_DIV;
            S_DIV:         state_next = (&ldone && steps_reg == '0) ? S_OUT : S_DIV;
            S_OUT:         state_next = (!ovalid_reg || !out_stall) ? S_IDLE : S_OUT;
            default:       state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        idx_next        = idx_reg;
        count_next      = count_reg;
        last_time_next  = last_time_reg;
        first_time_next = first_time_reg;
        t1_next         = t1_reg;
        t2_next         = t2_reg;
        y2_next         = y2_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        steps_next      = steps_reg;
        st_next         = st_reg;
        tout_next       = tout_reg;
        vout_next       = vout_reg;
        ovalid_next     = ovalid_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_time         = rd_time_reg;
        wr_vals         = rd_vals_reg;
        lctl.start      = 1'b0;
        lctl.dt         = t_reg - t1_reg;
        lctl.span       = t2_reg - t1_reg;
        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    idx_next  = in_idx;
                    st_next   = ST_OK;
                    tout_next = '0;
                    vout_next = '0;
                    if (in_cmd == CMD_APPEND)
                    begin
                        if (count_reg >= CountW'(Depth))
                            st_next = ST_FULL;
                        else if (count_reg != '0 && in_time <= last_time_reg)
                            st_next = ST_NOT_INCR;
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = AddrW'(count_reg);
                            wr_time = in_time;
                            for (int i = 0; i < NumCols; i++)
                                wr_vals[i*32 +: 32] = (3'(i) < ncols) ? in_vals[i*32 +: 32]
                                                                      : 32'd0;
                            if (count_reg == '0)
                                first_time_next = in_time;
                            last_time_next = in_time;
                            count_next     = count_reg + 1'b1;
                        end
                    end
                    else if (in_cmd == CMD_QUERY)
                    begin
                        if (count_reg == '0)
                            st_next = ST_BAD_IDX;
                    end
                    else if (CountW'(in_idx) >= count_reg)
                        st_next = ST_BAD_IDX;
                end
            S_RD:
            begin
                // remove fetches the row below, which becomes last when the last row goes
                rd_en = 1'b1;
                rd_addr = (cmd_reg == CMD_REMOVE && idx_reg != '0) ? idx_reg - 1'b1
                                                                   : idx_reg;
            end
            S_WAIT:
                if (cmd_reg != CMD_REMOVE)
                begin
                    if (cmd_reg == CMD_READ)
                        tout_next = rd_time_reg;
                    for (int i = 0; i < NumCols; i++)
                        vout_next[i*32 +: 32] = (3'(i) < ncols) ? rd_vals_reg[i*32 +: 32]
                                                                : 32'd0;
                end
                else
                    t1_next = rd_time_reg;
            S_DECIDE:
                if (t_reg == first_time_reg)
                    idx_next = '0;
                else if (t_reg < first_time_reg || t_reg > last_time_reg)
                    st_next = ST_RANGE;
                else
                begin
                    lo_next = AddrW'(1);
                    hi_next = AddrW'(count_reg - 1'b1);
                end
            S_SHIFT_RD:
                if (CountW'(idx_reg) + 1'b1 >= count_reg)
                begin
                    // last row dropped: refresh cached bounds
                    count_next = count_reg - 1'b1;
                    if (idx_reg == '0 && count_reg > CountW'(1))
                        first_time_next = rd_time_reg;
                    if (CountW'(idx_reg) + 1'b1 == count_reg && count_reg > CountW'(1))
                        last_time_next = t1_reg;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_reg + 1'b1;
                end
            S_SHIFT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (idx_reg == '0)
                    first_time_next = rd_time_reg;
                t1_next  = rd_time_reg;
                idx_next = idx_reg + 1'b1;
            end
            S_SEARCH:
                if (lo_reg != hi_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = mid;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = lo_reg;
                end
            S_SEARCH_WAIT:
                if (rd_time_reg < t_reg)
                    lo_next = mid + 1'b1;
                else
                    hi_next = mid;
            S_PREV_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = lo_reg - 1'b1;
                t2_next = rd_time_reg;
                y2_next = rd_vals_reg;
            end
            S_PREV_WAIT:
            begin
                t1_next    = rd_time_reg;
                steps_next = 7'd2;
            end
            S_DIV:
            begin
                lctl.start = (steps_reg == 7'd2);
                if (steps_reg != '0)
                    steps_next = steps_reg - 7'd1;
                if (&ldone && steps_reg == '0)
                    for (int i = 0; i < NumCols; i++)
                        vout_next[i*32 +: 32] = (3'(i) < ncols) ? lres[i*32 +: 32] : 32'd0;
            end
            S_OUT:
                if (!ovalid_reg || !out_stall)
                    ovalid_next = 1'b1;
            default: ;
        endcase
    end

    // Lanes, one per column; rd_vals holds the lower row during division
    for (genvar g = 0; g < NumCols; g++)
    begin : g_lane
        itst_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (lctl),
            .y1     (rd_vals_reg[g*32 +: 32]),
            .y2     (y2_reg[g*32 +: 32]),
            .done   (ldone[g]),
            .result (lres[g*32 +: 32])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
            steps_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
            steps_reg  <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= in_cmd;
            t_reg   <= in_time;
        end
        idx_reg        <= idx_next;
        last_time_reg  <= last_time_next;
        first_time_reg <= first_time_next;
        t1_reg         <= t1_next;
        t2_reg         <= t2_next;
        y2_reg         <= y2_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        st_reg         <= st_next;
        tout_reg       <= tout_next;
        vout_reg       <= vout_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign out_valid  = ovalid_reg;
    assign out_status = st_reg;
    assign out_time   = tout_reg;
    assign out_vals   = vout_reg;
    assign out_count  = 7'(count_reg);

    // Row count never exceeds the table depth
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountW'(Depth)) else $error("row count overflow");
    // A command is accepted only in the idle state
    a_idle_new: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> state_reg == S_IDLE) else $error("accept while busy");
    // Count changes only by one per step
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
        (count_reg == $past(count_reg) + 1'b1 || count_reg == $past(count_reg) - 1'b1))
        else $error("row count jumped");

endmodule
